### rtl/tccb_pkg.sv
package tccb_pkg;

  // Screen geometry and store size
  localparam int unsigned ROWS      = 10;
  localparam int unsigned COLS      = 50;
  localparam int unsigned CELLS     = ROWS * COLS;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned COPY_LAST = (ROWS - 1) * COLS - 1;

  // Escape count
  localparam int unsigned COUNT_MAX = 255;
  localparam int unsigned CNT_W     = $clog2(COUNT_MAX + 1);

  // Word field widths
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned CHAR_W = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_UPPER_C  = 8'h43;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SPACE,
    ST_SCROLL,
    ST_BLANK,
    ST_FILL,
    ST_RESULT
  } state_e;

endpackage

### rtl/tccb_if.sv
interface tccb_in_if;
  logic                          valid;
  logic                          ready;
  tccb_pkg::cmd_e                command;
  logic [tccb_pkg::CHAR_W-1:0]   char_code;
  logic [tccb_pkg::ROW_W-1:0]    read_row;
  logic [tccb_pkg::COL_W-1:0]    read_column;

  modport source (output valid, input ready, output command, output char_code,
                  output read_row, output read_column);
  modport sink   (input valid, output ready, input command, input char_code,
                  input read_row, input read_column);
endinterface

interface tccb_out_if;
  logic                          valid;
  logic                          ready;
  logic [tccb_pkg::CHAR_W-1:0]   cell_data;
  logic [tccb_pkg::ROW_W-1:0]    cursor_row;
  logic [tccb_pkg::COL_W-1:0]    cursor_column;
  logic                          escape_active;

  modport source (output valid, input ready, output cell_data, output cursor_row,
                  output cursor_column, output escape_active);
  modport sink   (input valid, output ready, input cell_data, input cursor_row,
                  input cursor_column, input escape_active);
endinterface

### rtl/text_console_cell_buffer_unit.sv
// A cell read passes through ST_READ before the result word; a scroll first copies each row up
// through the store's one write port, then blanks the bottom row.
// ESC [ n C: the C writes n spaces, plus a scroll per line wrap; clear refills the whole store.
// One word in flight at a time.
// Reset: asynchronous, active low; a clearing pass fills the store with spaces, and no word is
// accepted until it ends.
module text_console_cell_buffer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  tccb_in_if.sink        in_i,
  tccb_out_if.source     out_o
);

  localparam int unsigned NW = tccb_pkg::CNT_W + 4;

  tccb_pkg::state_e                  state_q, state_d;
  logic [tccb_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic [tccb_pkg::ADDR_W-1:0]       paddr_q, paddr_d;
  logic                              pend_q, pend_d;
  logic [tccb_pkg::ROW_W-1:0]        row_q, row_d;
  logic [tccb_pkg::COL_W-1:0]        col_q, col_d;
  logic                              esc_q, esc_d;
  logic [tccb_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [tccb_pkg::CNT_W-1:0]        rem_q, rem_d;
  logic [tccb_pkg::CHAR_W-1:0]       data_q, data_d;

  logic                              out_valid_q, out_valid_d;
  logic [tccb_pkg::CHAR_W-1:0]       out_data_q;
  logic [tccb_pkg::ROW_W-1:0]        out_row_q;
  logic [tccb_pkg::COL_W-1:0]        out_col_q;
  logic                              out_esc_q;
  logic                              load_out;

  logic [tccb_pkg::CHAR_W-1:0]       mem_q [tccb_pkg::CELLS];
  logic [tccb_pkg::CHAR_W-1:0]       rdata_q;
  logic                              mem_we;
  logic [tccb_pkg::ADDR_W-1:0]       mem_waddr;
  logic [tccb_pkg::ADDR_W-1:0]       mem_raddr;
  logic [tccb_pkg::CHAR_W-1:0]       mem_wdata;

  logic                              in_ready;
  logic                              in_acc;
  logic [tccb_pkg::CHAR_W-1:0]       ch;
  logic [tccb_pkg::ADDR_W-1:0]       cur_addr;
  logic [tccb_pkg::ADDR_W-1:0]       rd_addr;
  logic                              rd_in_range;
  logic                              adv_wrap;
  logic [tccb_pkg::COL_W-1:0]        adv_col;
  logic [tccb_pkg::ROW_W-1:0]        adv_row;
  logic                              adv_scroll;
  logic                              is_digit;
  logic [NW-1:0]                     digit_sum;
  logic [tccb_pkg::CNT_W-1:0]        cnt_next;
  logic                              last_row;

  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid & in_ready;
  assign ch         = in_i.char_code;

  // Cell addresses of the cursor and of the requested read
  assign cur_addr = tccb_pkg::ADDR_W'(row_q) * tccb_pkg::ADDR_W'(tccb_pkg::COLS)
                  + tccb_pkg::ADDR_W'(col_q);
  assign rd_addr  = tccb_pkg::ADDR_W'(in_i.read_row) * tccb_pkg::ADDR_W'(tccb_pkg::COLS)
                  + tccb_pkg::ADDR_W'(in_i.read_column);
  assign rd_in_range = (in_i.read_row < tccb_pkg::ROW_W'(tccb_pkg::ROWS))
                     && (in_i.read_column < tccb_pkg::COL_W'(tccb_pkg::COLS));

  // Advance the cursor by one stored cell; the last column is skipped
  assign last_row   = (row_q == tccb_pkg::ROW_W'(tccb_pkg::ROWS - 1));
  assign adv_wrap   = (col_q == tccb_pkg::COL_W'(tccb_pkg::COLS - 2));
  assign adv_col    = adv_wrap ? '0 : col_q + 1'b1;
  assign adv_row    = (adv_wrap && !last_row) ? row_q + 1'b1 : row_q;
  assign adv_scroll = adv_wrap && last_row;

  // Accumulate an escape digit with saturation
  assign is_digit  = (ch >= tccb_pkg::CH_ZERO) && (ch <= tccb_pkg::CH_NINE);
  assign digit_sum = NW'(cnt_q) * NW'(10) + NW'(ch[3:0]);
  assign cnt_next  = (digit_sum > NW'(tccb_pkg::COUNT_MAX))
                   ? tccb_pkg::CNT_W'(tccb_pkg::COUNT_MAX) : digit_sum[tccb_pkg::CNT_W-1:0];

  // Next state, store port control and cursor update
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    paddr_d   = addr_q;
    pend_d    = (state_q == tccb_pkg::ST_SCROLL);
    row_d     = row_q;
    col_d     = col_q;
    esc_d     = esc_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    data_d    = data_q;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = tccb_pkg::CH_SPACE;
    mem_raddr = rd_addr;

    unique case (state_q)
      tccb_pkg::ST_INIT, tccb_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        if (addr_q == tccb_pkg::ADDR_W'(tccb_pkg::CELLS - 1)) begin
          addr_d = '0;
          if (state_q == tccb_pkg::ST_INIT) begin
            state_d = tccb_pkg::ST_IDLE;
          end else begin
            // newline after clear: a scroll of a blank screen changes nothing
            col_d   = '0;
            row_d   = last_row ? row_q : row_q + 1'b1;
            state_d = tccb_pkg::ST_RESULT;
          end
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      tccb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          data_d  = '0;
          state_d = tccb_pkg::ST_RESULT;
          unique case (in_i.command)
            tccb_pkg::CMD_WRITE: begin
              if (ch == tccb_pkg::CH_ESC) begin
                esc_d = 1'b1;
              end else if (ch == tccb_pkg::CH_LF) begin
                col_d = '0;
                if (last_row) begin
                  addr_d  = '0;
                  state_d = tccb_pkg::ST_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (ch == tccb_pkg::CH_CR) begin
                col_d = '0;
              end else if (esc_q) begin
                if (ch == tccb_pkg::CH_LBRACKET) begin
                  esc_d = 1'b1;
                end else if (is_digit) begin
                  cnt_d = cnt_next;
                end else begin
                  esc_d = 1'b0;
                  cnt_d = '0;
                  if (ch == tccb_pkg::CH_UPPER_C && cnt_q != '0) begin
                    rem_d   = cnt_q;
                    state_d = tccb_pkg::ST_SPACE;
                  end
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = ch;
                col_d     = adv_col;
                row_d     = adv_row;
                if (adv_scroll) begin
                  addr_d  = '0;
                  state_d = tccb_pkg::ST_SCROLL;
                end
              end
            end
            tccb_pkg::CMD_READ: begin
              if (rd_in_range) begin
                state_d = tccb_pkg::ST_READ;
              end
            end
            tccb_pkg::CMD_CLEAR: begin
              addr_d  = '0;
              state_d = tccb_pkg::ST_FILL;
            end
            tccb_pkg::CMD_NONE: begin
              state_d = tccb_pkg::ST_RESULT;
            end
          endcase
        end
      end

      tccb_pkg::ST_READ: begin
        data_d  = rdata_q;
        state_d = tccb_pkg::ST_RESULT;
      end

      // Write one space of an escape run
      tccb_pkg::ST_SPACE: begin
        mem_we = 1'b1;
        col_d  = adv_col;
        row_d  = adv_row;
        rem_d  = rem_q - 1'b1;
        if (adv_scroll) begin
          addr_d  = '0;
          state_d = tccb_pkg::ST_SCROLL;
        end else if (rem_q == tccb_pkg::CNT_W'(1)) begin
          state_d = tccb_pkg::ST_RESULT;
        end
      end

      // Copy each cell one row up: read here, write on the next cycle
      tccb_pkg::ST_SCROLL: begin
        mem_raddr = addr_q + tccb_pkg::ADDR_W'(tccb_pkg::COLS);
        if (addr_q == tccb_pkg::ADDR_W'(tccb_pkg::COPY_LAST)) begin
          addr_d  = tccb_pkg::ADDR_W'(tccb_pkg::COPY_LAST + 1);
          state_d = tccb_pkg::ST_BLANK;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      // Blank the bottom row once the last copy has landed
      tccb_pkg::ST_BLANK: begin
        if (!pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          if (addr_q == tccb_pkg::ADDR_W'(tccb_pkg::CELLS - 1)) begin
            addr_d  = '0;
            state_d = (rem_q != '0) ? tccb_pkg::ST_SPACE : tccb_pkg::ST_RESULT;
          end else begin
            addr_d = addr_q + 1'b1;
          end
        end
      end

      tccb_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = tccb_pkg::ST_IDLE;
        end
      end
    endcase

    // Pending row copy owns the write port
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = paddr_q;
      mem_wdata = rdata_q;
    end
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_o.ready);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccb_pkg::ST_INIT;
      addr_q      <= '0;
      paddr_q     <= '0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      esc_q       <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      paddr_q     <= paddr_d;
      pend_q      <= pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      esc_q       <= esc_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload of the result word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (load_out) begin
      out_data_q <= data_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_esc_q  <= esc_q;
    end
  end

  // Cell store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_data     = out_data_q;
  assign out_o.cursor_row    = out_row_q;
  assign out_o.cursor_column = out_col_q;
  assign out_o.escape_active = out_esc_q;

endmodule

### verif/text_console_cell_buffer_unit_checker.sv
`timescale 1ns / 100ps

module text_console_cell_buffer_unit_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  tccb_in_if    in_w,
  tccb_out_if   out_w,
  output int    errors_o,
  output int    pending_o,
  output int    checked_o,
  output int    scrolls_o
);
  import tccb_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              esc;
  } console_word_t;

  console_word_t     expected_q [$];
  logic [CHAR_W-1:0] screen_mem [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  int unsigned       esc_num;
  logic              esc_open;

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_mem[i] = CH_SPACE;
  endfunction

  // Move every row up by one and blank the bottom row
  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_mem[i] = screen_mem[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_mem[i] = CH_SPACE;
    scrolls_o++;
  endfunction

  // Wrap at the last usable column, scroll when moving below the last row
  function automatic void settle_cursor();
    if (cur_col >= COLS - 1) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row >= ROWS && cur_col == 0) begin
      cur_row = ROWS - 1;
      scroll_screen();
    end
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] b);
    if (cur_row < ROWS && cur_col < COLS) screen_mem[cur_row * COLS + cur_col] = b;
    cur_col++;
    settle_cursor();
  endfunction

  // Byte inside an escape: skip '[', build the count, or close the sequence
  function automatic void escape_char(logic [CHAR_W-1:0] b);
    int unsigned n;
    if (b == CH_LBRACKET) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      n = esc_num * 10 + (b - CH_ZERO);
      esc_num = (n > COUNT_MAX) ? COUNT_MAX : n;
      return;
    end
    esc_open = 1'b0;
    n = esc_num;
    esc_num = 0;
    if (b == CH_UPPER_C) repeat (n) put_char(CH_SPACE);
  endfunction

  function automatic void write_char(logic [CHAR_W-1:0] b);
    if (b == CH_ESC) begin
      esc_open = 1'b1;
    end else if (b == CH_LF) begin
      cur_row++;
      cur_col = 0;
    end else if (b == CH_CR) begin
      cur_col = 0;
    end else if (esc_open) begin
      escape_char(b);
      return;
    end else begin
      put_char(b);
      return;
    end
    settle_cursor();
  endfunction

  function automatic console_word_t console_step(cmd_e cmd, logic [CHAR_W-1:0] ch,
                                                 logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    console_word_t w;
    w = '0;
    case (cmd)
      CMD_WRITE: write_char(ch);
      CMD_READ: begin
        if (rr < ROWS && rc < COLS) w.data = screen_mem[rr * COLS + rc];
      end
      CMD_CLEAR: begin
        blank_screen();
        write_char(CH_LF);
      end
      default: ;
    endcase
    w.row = cur_row[ROW_W-1:0];
    w.col = cur_col[COL_W-1:0];
    w.esc = esc_open;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    console_word_t got;
    console_word_t want;
    if (!rst_ni) begin
      blank_screen();
      cur_row = 0;
      cur_col = 0;
      esc_num = 0;
      esc_open = 1'b0;
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
      checked_o = 0;
      scrolls_o = 0;
    end else begin
      // Predict the result of each accepted command word
      if (in_w.valid && in_w.ready) begin
        expected_q.push_back(console_step(in_w.command, in_w.char_code,
                                          in_w.read_row, in_w.read_column));
      end
      // Compare each accepted result word with the oldest prediction
      if (out_w.valid && out_w.ready) begin
        got = {out_w.cell_data, out_w.cursor_row, out_w.cursor_column, out_w.escape_active};
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result word with nothing expected: data %02h row %0d col %0d esc %0b",
                     $realtime, got.data, got.row, got.col, got.esc);
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (got.data !== want.data || got.row !== want.row ||
              got.col !== want.col || got.esc !== want.esc) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch: expected data %02h row %0d col %0d esc %0b, got data %02h row %0d col %0d esc %0b",
                       $realtime, want.data, want.row, want.col, want.esc,
                       got.data, got.row, got.col, got.esc);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### verif/text_console_cell_buffer_unit_test.sv
`timescale 1ns / 100ps

module text_console_cell_buffer_unit_test;
  import tccb_pkg::*;

  localparam int unsigned WORD_TARGET  = 600;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = CELLS + 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady   = 1'b0;  // no idling on either side while set
  bit   hold_req = 1'b0;
  int   words_sent   = 0;
  int   reads_sent   = 0;
  int   clears_sent  = 0;
  int   escapes_sent = 0;
  int   err_count;
  int   exp_pending;
  int   checked;
  int   scrolls;

  tccb_in_if  cmd_bus ();
  tccb_out_if cell_bus ();

  text_console_cell_buffer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (cell_bus)
  );

  text_console_cell_buffer_unit_checker cell_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_w      (cmd_bus),
    .out_w     (cell_bus),
    .errors_o  (err_count),
    .pending_o (exp_pending),
    .checked_o (checked),
    .scrolls_o (scrolls)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    cell_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        cell_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        cell_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Abort a hung run
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still expected", cycles, exp_pending);
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one command word at a falling edge and hold it until accepted
  task automatic send_word(cmd_e cmd, logic [CHAR_W-1:0] ch,
                           logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= cmd;
    cmd_bus.char_code   <= ch;
    cmd_bus.read_row    <= rr;
    cmd_bus.read_column <= rc;
    do @(posedge clk_i); while (!cmd_bus.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_char(logic [CHAR_W-1:0] b);
    send_word(CMD_WRITE, b, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic send_read(logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    reads_sent++;
    send_word(CMD_READ, CHAR_W'($urandom), rr, rc);
  endtask

  task automatic send_clear();
    clears_sent++;
    send_word(CMD_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    b = ($urandom_range(9) != 0) ? CHAR_W'($urandom_range(8'h7E, 8'h20)) : CHAR_W'($urandom);
    return (b == CH_ESC) ? CH_SPACE : b;
  endfunction

  // ESC, an optional [, a count and C, or a sequence closed by some other byte
  task automatic send_escape(bit well_formed);
    string             digits;
    int unsigned       k;
    int unsigned       n;
    logic [CHAR_W-1:0] end_byte;
    k = $urandom_range(99);
    n = (k < 70) ? $urandom_range(20, 0) :
        (k < 95) ? $urandom_range(99, 21) : $urandom_range(999, 100);
    digits = $sformatf("%0d", n);
    escapes_sent++;
    send_char(CH_ESC);
    if ($urandom_range(3) != 0) send_char(CH_LBRACKET);
    // newline, return or a second ESC inside the sequence
    if ($urandom_range(9) == 0) begin
      k = $urandom_range(2);
      send_char(k == 0 ? CH_LF : k == 1 ? CH_CR : CH_ESC);
    end
    if (well_formed || $urandom_range(1) == 1) begin
      for (int i = 0; i < digits.len(); i++) send_char(digits[i]);
    end
    if (well_formed) end_byte = CH_UPPER_C;
    else if ($urandom_range(1) == 1) end_byte = CHAR_W'($urandom_range(8'h5A, 8'h44));
    else end_byte = CHAR_W'($urandom_range(8'hFF, 8'h80));
    send_char(end_byte);
  endtask

  initial begin
    int unsigned r;
    int unsigned len;
    int          first_random;
    bit          held;
    held = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.command     = CMD_WRITE;
    cmd_bus.char_code   = '0;
    cmd_bus.read_row    = '0;
    cmd_bus.read_column = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: read extremes, byte zero and 0xFF, controls, escapes, a no-op word, clear
    send_read(ROW_W'(0), COL_W'(0));
    send_read(ROW_W'(15), COL_W'(63));
    send_read(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
    send_char(8'h00);
    send_char(8'hFF);
    send_read(ROW_W'(0), COL_W'(0));
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_ESC);
    send_char(CH_LBRACKET);
    send_char("1");
    send_char("2");
    send_char(CH_UPPER_C);
    send_char(CH_ESC);
    send_char(CH_LF);
    send_char(CH_ESC);
    send_char("9");
    send_char("9");
    send_char("9");
    send_char(CH_UPPER_C);
    send_char(CH_ESC);
    send_char("x");
    send_word(CMD_NONE, 8'hFF, ROW_W'(15), COL_W'(63));
    send_clear();
    send_read(ROW_W'(1), COL_W'(COLS - 1));

    // Random: mostly text, controls and well-formed escapes
    first_random = words_sent;
    while (words_sent - first_random < WORD_TARGET) begin
      if (!held && words_sent - first_random >= 150) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      steady = (words_sent - first_random >= 250) && (words_sent - first_random < 350);
      r = $urandom_range(99);
      if (r < 45) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(60, 20);
        repeat (len) send_char(text_byte());
      end else if (r < 57) begin
        send_char($urandom_range(1) ? CH_LF : CH_CR);
      end else if (r < 72) begin
        send_escape(1'b1);
      end else if (r < 78) begin
        send_escape(1'b0);
      end else if (r < 92) begin
        if ($urandom_range(9) != 0) begin
          send_read(ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLS - 1)));
        end else begin
          send_read(ROW_W'($urandom), COL_W'($urandom));
        end
      end else if (r < 95) begin
        send_clear();
      end else if (r < 97) begin
        send_word(CMD_NONE, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end else begin
        send_char(CHAR_W'($urandom));
      end
    end
    steady = 1'b0;
    cmd_bus.valid <= 1'b0;

    // Drain, then give the block time to show any stray result
    wait (exp_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words: %0d reads, %0d clears, %0d escape sequences.",
             words_sent, reads_sent, clears_sent, escapes_sent);
    $display("Checked %0d result words over %0d scrolls, with one %0d-cycle result stall.",
             checked, scrolls, HOLD_CYCLES);
    if (err_count == 0 && exp_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/tccb_pkg.sv
rtl/tccb_if.sv
rtl/text_console_cell_buffer_unit.sv
verif/text_console_cell_buffer_unit_checker.sv
verif/text_console_cell_buffer_unit_test.sv
